// File: rtl/cpu8080_pkg.sv
// ----------------------------------------------------------------------------
// cpu8080_pkg
// Shared types and constants of the 8080-compatible core.
// ----------------------------------------------------------------------------
package cpu8080_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_EXEC  = 2'd2,
    CMD_RAISE = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HRD,
    ST_OPCAP,
    ST_DECODE,
    ST_IMM1,
    ST_IMM2,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_WR0,
    ST_WR1,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic        we;
    logic        re;
    logic [15:0] addr;
    logic [7:0]  wdata;
  } mem_req_t;

  localparam logic [7:0] HLT_OP     = 8'h76;
  localparam logic [7:0] FLAG_FIXED = 8'h02;
  localparam logic [7:0] FLAG_MASK  = 8'hD7;
  localparam logic [3:0] BCD_MAX    = 4'd9;
  localparam logic [7:0] ADJ_LO     = 8'h06;
  localparam logic [7:0] ADJ_HI     = 8'h60;

endpackage

// File: rtl/cpu8080_if.sv
// ----------------------------------------------------------------------------
// cpu8080 channel interfaces
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface cpu8080_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [15:0] address;
  logic [7:0]  data;
  logic [7:0]  port_in_data;

  modport source (output valid, command, address, data, port_in_data, input ready);
  modport sink   (input valid, command, address, data, port_in_data, output ready);
endinterface

interface cpu8080_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic        port_write;
  logic        port_read;
  logic [7:0]  port_number;
  logic [7:0]  port_out_data;
  logic        halted_now;
  logic [15:0] program_counter;
  logic [7:0]  accumulator;
  logic [7:0]  flag_byte;

  modport source (output valid, read_data, port_write, port_read, port_number,
                  port_out_data, halted_now, program_counter, accumulator,
                  flag_byte, input ready);
  modport sink   (input valid, read_data, port_write, port_read, port_number,
                  port_out_data, halted_now, program_counter, accumulator,
                  flag_byte, output ready);
endinterface

// File: rtl/cpu8080_mem.sv
// ----------------------------------------------------------------------------
// cpu8080_mem
// Single-port main memory with a registered read port.
// ----------------------------------------------------------------------------
module cpu8080_mem #(
  parameter int AddrBits = 16
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic                re_i,
  input  logic [AddrBits-1:0] addr_i,
  input  logic [7:0]          wdata_i,
  output logic [7:0]          rdata_o
);

  localparam int Depth = 1 << AddrBits;

  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/cpu8080_exec.sv
// ----------------------------------------------------------------------------
// cpu8080_exec
// Sequencer, register file and ALU; drives the memory port with at most one access a cycle.
// ----------------------------------------------------------------------------
module cpu8080_exec import cpu8080_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  cpu8080_req_if.sink          req,
  cpu8080_rsp_if.source        rsp,
  output mem_req_t             mem_req_o,
  input  logic [7:0]           mem_rdata_i
);

  function automatic logic [7:0] mkf(input logic [7:0] v, input logic ac, input logic cy);
    mkf = {v[7], (v == 8'd0), 1'b0, ac, 1'b0, ~^v, 1'b1, cy};
  endfunction

  function automatic logic cond_ok(input logic [2:0] cc, input logic [7:0] f);
    logic s;
    case (cc[2:1])
      2'd0:    s = f[6];
      2'd1:    s = f[0];
      2'd2:    s = f[2];
      default: s = f[7];
    endcase
    cond_ok = cc[0] ? s : !s;
  endfunction

  // Returns {flags, result}.
  function automatic logic [15:0] alu(input logic [2:0] op, input logic [7:0] a,
                                      input logic [7:0] b, input logic [7:0] f);
    logic [8:0] r;
    logic [4:0] n;
    logic       cin;
    logic [7:0] nb;
    nb = ~b;
    case (op)
      3'd0, 3'd1: begin
        cin = (op == 3'd1) && f[0];
        r   = {1'b0, a} + {1'b0, b} + {8'd0, cin};
        n   = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
        alu = {mkf(r[7:0], n[4], r[8]), r[7:0]};
      end
      3'd2, 3'd3, 3'd7: begin
        cin = !((op == 3'd3) && f[0]);
        r   = {1'b0, a} + {1'b0, nb} + {8'd0, cin};
        n   = {1'b0, a[3:0]} + {1'b0, nb[3:0]} + {4'd0, cin};
        alu = {mkf(r[7:0], n[4], !r[8]), r[7:0]};
      end
      3'd4:    alu = {mkf(a & b, a[3] | b[3], 1'b0), a & b};
      3'd5:    alu = {mkf(a ^ b, 1'b0, 1'b0), a ^ b};
      default: alu = {mkf(a | b, 1'b0, 1'b0), a | b};
    endcase
  endfunction

  state_e      state_q, state_d;
  logic [7:0]  a_q, b_q, c_q, d_q, e_q, h_q, l_q, f_q;
  logic [7:0]  a_d, b_d, c_d, d_d, e_d, h_d, l_d, f_d;
  logic [15:0] sp_q, sp_d, pc_q, pc_d;
  logic        ie_q, ie_d, pend_q, pend_d, halt_q, halt_d;
  logic [7:0]  iop_q, iop_d;
  logic [7:0]  op_q, op_d, lo_q, lo_d, hi_q, hi_d, rlo_q, rlo_d, rhi_q, rhi_d;
  logic [7:0]  pin_q, pin_d;

  logic        out_valid_q;
  logic [7:0]  o_rd_q, o_pnum_q, o_pout_q, o_a_q, o_f_q;
  logic        o_pw_q, o_pr_q, o_halt_q;
  logic [15:0] o_pc_q;

  logic        out_free, in_fire, finish;
  logic        io_wr, io_rd;
  logic [7:0]  rd_out;

  logic [2:0]  y, z;
  logic [1:0]  p;
  logic [15:0] hl, t, pair_p;
  logic [7:0]  rv [8];
  logic        cnd;
  logic [1:0]  nimm, nr, nw;
  logic [15:0] rbase, wbase;
  logic [7:0]  wlo, whi;

  assign y        = op_q[5:3];
  assign z        = op_q[2:0];
  assign p        = op_q[5:4];
  assign hl       = {h_q, l_q};
  assign t        = {hi_q, lo_q};
  assign cnd      = cond_ok(y, f_q);
  assign out_free = !out_valid_q || rsp.ready;
  assign req.ready = (state_q == ST_IDLE) && out_free;
  assign in_fire  = req.valid && req.ready;

  // Register sources indexed by the 3-bit field; index 6 is the byte read at HL.
  assign rv[0] = b_q;
  assign rv[1] = c_q;
  assign rv[2] = d_q;
  assign rv[3] = e_q;
  assign rv[4] = h_q;
  assign rv[5] = l_q;
  assign rv[6] = rlo_q;
  assign rv[7] = a_q;

  always_comb begin
    case (p)
      2'd0:    pair_p = {b_q, c_q};
      2'd1:    pair_p = {d_q, e_q};
      2'd2:    pair_p = hl;
      default: pair_p = sp_q;
    endcase
  end

  // Access plan: operand bytes, data reads and data writes of the instruction.
  always_comb begin
    nimm  = 2'd0;
    nr    = 2'd0;
    nw    = 2'd0;
    rbase = hl;
    wbase = hl;
    wlo   = a_q;
    whi   = 8'd0;
    case (op_q[7:6])
      2'b00: begin
        case (z)
          3'd1: if (!op_q[3]) nimm = 2'd2;
          3'd2: begin
            if (y[2]) nimm = 2'd2;
            case (y)
              3'd0, 3'd2: begin nw = 2'd1; wbase = pair_p; end
              3'd1, 3'd3: begin nr = 2'd1; rbase = pair_p; end
              3'd4: begin nw = 2'd2; wbase = t; wlo = l_q; whi = h_q; end
              3'd5: begin nr = 2'd2; rbase = t; end
              3'd6: begin nw = 2'd1; wbase = t; end
              default: begin nr = 2'd1; rbase = t; end
            endcase
          end
          3'd4: if (y == 3'd6) begin nr = 2'd1; nw = 2'd1; wlo = rlo_q + 8'd1; end
          3'd5: if (y == 3'd6) begin nr = 2'd1; nw = 2'd1; wlo = rlo_q - 8'd1; end
          3'd6: begin
            nimm = 2'd1;
            if (y == 3'd6) begin nw = 2'd1; wlo = lo_q; end
          end
          default: ;
        endcase
      end
      2'b01: begin
        // The halt opcode sits in the move block but touches no memory.
        if (op_q != HLT_OP) begin
          if (z == 3'd6) nr = 2'd1;
          if (y == 3'd6) begin nw = 2'd1; wlo = rv[z]; end
        end
      end
      2'b10: if (z == 3'd6) nr = 2'd1;
      default: begin
        case (z)
          3'd0: if (cnd) begin nr = 2'd2; rbase = sp_q; end
          3'd1: if (!op_q[3] || !p[1]) begin nr = 2'd2; rbase = sp_q; end
          3'd2: nimm = 2'd2;
          3'd3: begin
            if (y == 3'd0 || y == 3'd1) nimm = 2'd2;
            if (y == 3'd2 || y == 3'd3) nimm = 2'd1;
            if (y == 3'd4) begin
              nr = 2'd2; rbase = sp_q; nw = 2'd2; wbase = sp_q; wlo = l_q; whi = h_q;
            end
          end
          3'd4: begin
            nimm = 2'd2;
            if (cnd) begin
              nw = 2'd2; wbase = sp_q - 16'd2; wlo = pc_q[7:0]; whi = pc_q[15:8];
            end
          end
          3'd5: begin
            nw    = 2'd2;
            wbase = sp_q - 16'd2;
            if (op_q[3]) begin
              nimm = 2'd2; wlo = pc_q[7:0]; whi = pc_q[15:8];
            end else if (p == 2'd3) begin
              wlo = f_q; whi = a_q;
            end else begin
              wlo = pair_p[7:0]; whi = pair_p[15:8];
            end
          end
          3'd6: nimm = 2'd1;
          default: begin
            nw = 2'd2; wbase = sp_q - 16'd2; wlo = pc_q[7:0]; whi = pc_q[15:8];
          end
        endcase
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (cmd_e'(req.command))
            CMD_READ: state_d = ST_HRD;
            CMD_EXEC: begin
              if (pend_q)       state_d = ST_DECODE;
              else if (!halt_q) state_d = ST_OPCAP;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_HRD:    if (out_free) state_d = ST_IDLE;
      ST_OPCAP:  state_d = ST_DECODE;
      ST_DECODE: state_d = (nimm != 2'd0) ? ST_IMM1 : ST_RD0;
      ST_IMM1:   state_d = (nimm == 2'd2) ? ST_IMM2 : ST_RD0;
      ST_IMM2:   state_d = ST_RD0;
      ST_RD0:    state_d = (nr != 2'd0) ? ST_RD1 : ST_WR0;
      ST_RD1:    state_d = (nr == 2'd2) ? ST_RD2 : ST_WR0;
      ST_RD2:    state_d = ST_WR0;
      ST_WR0:    state_d = (nw == 2'd2) ? ST_WR1 : ST_FIN;
      ST_WR1:    state_d = ST_FIN;
      ST_FIN:    if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Datapath, memory port and instruction completion.
  always_comb begin
    logic [7:0]  v;
    logic [15:0] alu_r;
    logic [16:0] dad;
    logic [7:0]  corr;
    logic        ncy;
    logic        pr_en;
    logic [15:0] pr_val;
    logic        r8_en;
    logic [7:0]  r8_val;

    v = 8'd0; alu_r = 16'd0; dad = 17'd0; corr = 8'd0; ncy = 1'b0;
    pr_en = 1'b0; pr_val = 16'd0; r8_en = 1'b0; r8_val = 8'd0;

    a_d = a_q; b_d = b_q; c_d = c_q; d_d = d_q; e_d = e_q; h_d = h_q; l_d = l_q;
    f_d = f_q; sp_d = sp_q; pc_d = pc_q; ie_d = ie_q; pend_d = pend_q;
    halt_d = halt_q; iop_d = iop_q; op_d = op_q; lo_d = lo_q; hi_d = hi_q;
    rlo_d = rlo_q; rhi_d = rhi_q; pin_d = pin_q;
    mem_req_o = '0;
    finish = 1'b0;
    io_wr  = 1'b0;
    io_rd  = 1'b0;
    rd_out = 8'd0;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (cmd_e'(req.command))
            CMD_WRITE: begin
              mem_req_o.we    = 1'b1;
              mem_req_o.addr  = req.address;
              mem_req_o.wdata = req.data;
              finish          = 1'b1;
            end
            CMD_READ: begin
              mem_req_o.re   = 1'b1;
              mem_req_o.addr = req.address;
            end
            CMD_EXEC: begin
              pin_d = req.port_in_data;
              if (pend_q) begin
                op_d = iop_q; pend_d = 1'b0; halt_d = 1'b0;
              end else if (halt_q) begin
                finish = 1'b1;
              end else begin
                mem_req_o.re   = 1'b1;
                mem_req_o.addr = pc_q;
                pc_d           = pc_q + 16'd1;
              end
            end
            default: begin
              if (ie_q) begin
                ie_d = 1'b0; pend_d = 1'b1; iop_d = req.data;
              end
              finish = 1'b1;
            end
          endcase
        end
      end
      ST_HRD: begin
        rd_out = mem_rdata_i;
        finish = out_free;
      end
      ST_OPCAP: op_d = mem_rdata_i;
      ST_DECODE: begin
        if (nimm != 2'd0) begin
          mem_req_o.re = 1'b1; mem_req_o.addr = pc_q; pc_d = pc_q + 16'd1;
        end
      end
      ST_IMM1: begin
        lo_d = mem_rdata_i;
        if (nimm == 2'd2) begin
          mem_req_o.re = 1'b1; mem_req_o.addr = pc_q; pc_d = pc_q + 16'd1;
        end
      end
      ST_IMM2: hi_d = mem_rdata_i;
      ST_RD0: begin
        if (nr != 2'd0) begin
          mem_req_o.re = 1'b1; mem_req_o.addr = rbase;
        end
      end
      ST_RD1: begin
        rlo_d = mem_rdata_i;
        if (nr == 2'd2) begin
          mem_req_o.re = 1'b1; mem_req_o.addr = rbase + 16'd1;
        end
      end
      ST_RD2: rhi_d = mem_rdata_i;
      ST_WR0: begin
        if (nw != 2'd0) begin
          mem_req_o.we = 1'b1; mem_req_o.addr = wbase; mem_req_o.wdata = wlo;
        end
      end
      ST_WR1: begin
        mem_req_o.we = 1'b1; mem_req_o.addr = wbase + 16'd1; mem_req_o.wdata = whi;
      end
      ST_FIN: begin
        if (out_free) begin
          finish = 1'b1;
          if (op_q == HLT_OP) begin
            halt_d = 1'b1;
          end else begin
            case (op_q[7:6])
              2'b01: begin
                r8_en = (y != 3'd6); r8_val = rv[z];
              end
              2'b10: begin
                alu_r = alu(y, a_q, rv[z], f_q);
                f_d   = alu_r[15:8];
                if (y != 3'd7) a_d = alu_r[7:0];
              end
              2'b00: begin
                case (z)
                  3'd1: begin
                    if (op_q[3]) begin
                      dad = {1'b0, hl} + {1'b0, pair_p};
                      h_d = dad[15:8]; l_d = dad[7:0];
                      f_d = {f_q[7:1], dad[16]};
                    end else begin
                      pr_en = 1'b1; pr_val = t;
                    end
                  end
                  3'd2: begin
                    case (y)
                      3'd1, 3'd3, 3'd7: a_d = rlo_q;
                      3'd5: begin l_d = rlo_q; h_d = rhi_q; end
                      default: ;
                    endcase
                  end
                  3'd3: begin
                    pr_en  = 1'b1;
                    pr_val = op_q[3] ? (pair_p - 16'd1) : (pair_p + 16'd1);
                  end
                  3'd4: begin
                    v = rv[y] + 8'd1;
                    r8_en = (y != 3'd6); r8_val = v;
                    f_d = mkf(v, v[3:0] == 4'd0, f_q[0]);
                  end
                  3'd5: begin
                    v = rv[y] - 8'd1;
                    r8_en = (y != 3'd6); r8_val = v;
                    f_d = mkf(v, v[3:0] != 4'hF, f_q[0]);
                  end
                  3'd6: begin
                    r8_en = (y != 3'd6); r8_val = lo_q;
                  end
                  3'd7: begin
                    ncy = f_q[0];
                    v   = a_q;
                    case (y)
                      3'd0: begin ncy = a_q[7]; v = {a_q[6:0], a_q[7]}; end
                      3'd1: begin ncy = a_q[0]; v = {a_q[0], a_q[7:1]}; end
                      3'd2: begin ncy = a_q[7]; v = {a_q[6:0], f_q[0]}; end
                      3'd3: begin ncy = a_q[0]; v = {f_q[0], a_q[7:1]}; end
                      3'd4: begin
                        if (f_q[4] || a_q[3:0] > BCD_MAX) corr = ADJ_LO;
                        if (f_q[0] || a_q[7:4] > BCD_MAX ||
                            (a_q[7:4] >= BCD_MAX && a_q[3:0] > BCD_MAX)) begin
                          corr = corr + ADJ_HI;
                          ncy  = 1'b1;
                        end
                        v = a_q + corr;
                      end
                      3'd5: v = ~a_q;
                      3'd6: ncy = 1'b1;
                      default: ncy = !f_q[0];
                    endcase
                    a_d = v;
                    if (y == 3'd4) begin
                      f_d = mkf(v, ({1'b0, a_q[3:0]} + {1'b0, corr[3:0]}) > 5'd15, ncy);
                    end else begin
                      f_d = {f_q[7:1], ncy};
                    end
                  end
                  default: ;
                endcase
              end
              default: begin
                case (z)
                  3'd0: if (cnd) begin pc_d = {rhi_q, rlo_q}; sp_d = sp_q + 16'd2; end
                  3'd1: begin
                    if (!op_q[3]) begin
                      sp_d = sp_q + 16'd2;
                      if (p == 2'd3) begin
                        a_d = rhi_q;
                        f_d = (rlo_q & FLAG_MASK) | FLAG_FIXED;
                      end else begin
                        pr_en = 1'b1; pr_val = {rhi_q, rlo_q};
                      end
                    end else if (!p[1]) begin
                      pc_d = {rhi_q, rlo_q}; sp_d = sp_q + 16'd2;
                    end else if (p == 2'd2) begin
                      pc_d = hl;
                    end else begin
                      sp_d = hl;
                    end
                  end
                  3'd2: if (cnd) pc_d = t;
                  3'd3: begin
                    case (y)
                      3'd0, 3'd1: pc_d = t;
                      3'd2: io_wr = 1'b1;
                      3'd3: begin io_rd = 1'b1; a_d = pin_q; end
                      3'd4: begin l_d = rlo_q; h_d = rhi_q; end
                      3'd5: begin h_d = d_q; l_d = e_q; d_d = h_q; e_d = l_q; end
                      3'd6: ie_d = 1'b0;
                      default: ie_d = 1'b1;
                    endcase
                  end
                  3'd4: if (cnd) begin sp_d = sp_q - 16'd2; pc_d = t; end
                  3'd5: begin
                    sp_d = sp_q - 16'd2;
                    if (op_q[3]) pc_d = t;
                  end
                  3'd6: begin
                    alu_r = alu(y, a_q, lo_q, f_q);
                    f_d   = alu_r[15:8];
                    if (y != 3'd7) a_d = alu_r[7:0];
                  end
                  default: begin
                    sp_d = sp_q - 16'd2;
                    pc_d = {10'd0, op_q[5:3], 3'd0};
                  end
                endcase
              end
            endcase
            if (pr_en) begin
              case (p)
                2'd0:    begin b_d = pr_val[15:8]; c_d = pr_val[7:0]; end
                2'd1:    begin d_d = pr_val[15:8]; e_d = pr_val[7:0]; end
                2'd2:    begin h_d = pr_val[15:8]; l_d = pr_val[7:0]; end
                default: sp_d = pr_val;
              endcase
            end
            if (r8_en) begin
              case (y)
                3'd0:    b_d = r8_val;
                3'd1:    c_d = r8_val;
                3'd2:    d_d = r8_val;
                3'd3:    e_d = r8_val;
                3'd4:    h_d = r8_val;
                3'd5:    l_d = r8_val;
                3'd7:    a_d = r8_val;
                default: ;
              endcase
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      a_q <= '0; b_q <= '0; c_q <= '0; d_q <= '0; e_q <= '0; h_q <= '0; l_q <= '0;
      f_q         <= FLAG_FIXED;
      sp_q        <= '0;
      pc_q        <= '0;
      ie_q        <= 1'b0;
      pend_q      <= 1'b0;
      halt_q      <= 1'b0;
      iop_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      a_q <= a_d; b_q <= b_d; c_q <= c_d; d_q <= d_d; e_q <= e_d; h_q <= h_d; l_q <= l_d;
      f_q     <= f_d;
      sp_q    <= sp_d;
      pc_q    <= pc_d;
      ie_q    <= ie_d;
      pend_q  <= pend_d;
      halt_q  <= halt_d;
      iop_q   <= iop_d;
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    rlo_q <= rlo_d;
    rhi_q <= rhi_d;
    pin_q <= pin_d;
    if (finish) begin
      o_rd_q   <= rd_out;
      o_pw_q   <= io_wr;
      o_pr_q   <= io_rd;
      o_pnum_q <= (io_wr || io_rd) ? lo_q : 8'd0;
      o_pout_q <= io_wr ? a_d : 8'd0;
      o_halt_q <= halt_d;
      o_pc_q   <= pc_d;
      o_a_q    <= a_d;
      o_f_q    <= f_d;
    end
  end

  assign rsp.valid           = out_valid_q;
  assign rsp.read_data       = o_rd_q;
  assign rsp.port_write      = o_pw_q;
  assign rsp.port_read       = o_pr_q;
  assign rsp.port_number     = o_pnum_q;
  assign rsp.port_out_data   = o_pout_q;
  assign rsp.halted_now      = o_halt_q;
  assign rsp.program_counter = o_pc_q;
  assign rsp.accumulator     = o_a_q;
  assign rsp.flag_byte       = o_f_q;

  // An interrupt is only latched with the enable cleared, and taking it
  // consumes it before any EI can run.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(pend_q && ie_q))
    else $error("interrupt pending while interrupts enabled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   f_q[1] && !f_q[5] && !f_q[3])
    else $error("fixed flag bits corrupted");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   !(mem_req_o.we && mem_req_o.re))
    else $error("read and write issued in the same cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (in_fire && cmd_e'(req.command) == CMD_WRITE) |=> rsp.valid)
    else $error("memory write request produced no response");

endmodule

// File: rtl/cpu_8080_core_unit.sv
// ----------------------------------------------------------------------------
// cpu_8080_core_unit
// 8080-compatible processor core with internal main memory.
// ----------------------------------------------------------------------------
// Each request writes a memory byte, reads one, executes one instruction or
// raises an interrupt, and yields exactly one response. All accesses share
// one single-port memory, at most one access per cycle, so the cost of a
// request is set by its memory traffic: a write, a raise or an execute on a
// halted core completes in idle, a read waits for the registered read data,
// and an instruction steps through fetch, decode, its operand bytes, its
// data reads and its data writes (a pending interrupt opcode needs no
// fetch). A new request is taken as soon as the sequencer is back in idle
// and the response register is free or being emptied.
module cpu_8080_core_unit import cpu8080_pkg::*; #(
  parameter int ADDRESS_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  cpu8080_req_if.sink   req_i,
  cpu8080_rsp_if.source rsp_o
);

  mem_req_t   mem_req;
  logic [7:0] mem_rdata;

  cpu8080_exec u_exec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req_i),
    .rsp         (rsp_o),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  cpu8080_mem #(
    .AddrBits (ADDRESS_BITS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .re_i    (mem_req.re),
    .addr_i  (mem_req.addr[ADDRESS_BITS-1:0]),
    .wdata_i (mem_req.wdata),
    .rdata_o (mem_rdata)
  );

endmodule
